@@ sv/backslash_escape_decoder_core_assert.svh @@
// Assertion macros shared by the decoder modules
`ifndef BACKSLASH_ESCAPE_DECODER_CORE_ASSERT_SVH
`define BACKSLASH_ESCAPE_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define BED_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, checked outside reset
`define BED_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

@@ sv/bed_pkg.sv @@
`default_nettype none

package bed_pkg;

  // Input transfer payload
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // Output transfer payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;
    logic       stopped_by_c;
  } out_item_t;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned CNT_W = 2;

  // All results caused by one input byte
  typedef struct packed {
    logic [CNT_W-1:0]                count;
    out_item_t [MAX_RESULTS-1:0]     items;
  } group_t;

  // escape_mode codes
  localparam logic [1:0] MODE_EXPAND = 2'd0;
  localparam logic [1:0] MODE_ECHO   = 2'd1;
  localparam logic [1:0] MODE_PRINTF = 2'd2;
  localparam logic [1:0] MODE_RESET  = MODE_EXPAND;

  // Source characters
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_E_UP   = 8'h45;
  localparam logic [7:0] CH_C      = 8'h63;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  // Decoded control codes
  localparam logic [7:0] CODE_LF  = 8'h0A;
  localparam logic [7:0] CODE_TAB = 8'h09;
  localparam logic [7:0] CODE_CR  = 8'h0D;
  localparam logic [7:0] CODE_BEL = 8'h07;
  localparam logic [7:0] CODE_BS  = 8'h08;
  localparam logic [7:0] CODE_FF  = 8'h0C;
  localparam logic [7:0] CODE_VT  = 8'h0B;
  localparam logic [7:0] CODE_ESC = 8'h1B;

  // Hex digit: {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= CH_0 && b <= CH_9) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= CH_LA && b <= CH_LF_HEX) || (b >= CH_UA && b <= CH_UF)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/bed_decode.sv @@
`default_nettype none

module bed_decode (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire bed_pkg::in_item_t item,
  input  wire logic [1:0]       escape_mode,
  output bed_pkg::group_t       grp
);

  `include "backslash_escape_decoder_core_assert.svh"

  typedef enum logic [2:0] {
    PH_TEXT = 3'd0,
    PH_ESC  = 3'd1,
    PH_OCT  = 3'd2,
    PH_HEX  = 3'd3,
    PH_STOP = 3'd4
  } phase_t;

  phase_t     phase, phase_next;
  logic [8:0] digit_value, digit_value_next;
  logic [1:0] digit_count, digit_count_next;

  logic       do_plain;
  logic       stopped;
  logic       mode_keeps_bslash;
  logic       mode_has_c;
  logic [4:0] hexd;
  logic       is_oct;

  // Append one data byte to the group
  function automatic bed_pkg::group_t put(input bed_pkg::group_t g, input logic [7:0] v);
    bed_pkg::group_t r;
    r = g;
    r.items[r.count] = '{out_byte: v, byte_valid: 1'b1, run_last: 1'b0,
                         string_end: 1'b0, stopped_by_c: 1'b0};
    r.count = r.count + 2'd1;
    return r;
  endfunction

  assign mode_keeps_bslash = (escape_mode == bed_pkg::MODE_ECHO);
  assign mode_has_c = (escape_mode == bed_pkg::MODE_EXPAND) ||
                      (escape_mode == bed_pkg::MODE_ECHO);
  assign hexd   = bed_pkg::hex_digit(item.in_byte);
  assign is_oct = (item.in_byte >= bed_pkg::CH_0) && (item.in_byte <= bed_pkg::CH_7);

  // One byte of decode: phase step, then plain text, then end-of-string flush
  always_comb begin
    grp              = '0;
    phase_next       = phase;
    digit_value_next = digit_value;
    digit_count_next = digit_count;
    do_plain         = 1'b0;
    stopped          = 1'b0;

    case (phase)
      PH_ESC: begin
        phase_next = PH_TEXT;
        case (item.in_byte)
          bed_pkg::CH_N:      grp = put(grp, bed_pkg::CODE_LF);
          bed_pkg::CH_T:      grp = put(grp, bed_pkg::CODE_TAB);
          bed_pkg::CH_R:      grp = put(grp, bed_pkg::CODE_CR);
          bed_pkg::CH_A:      grp = put(grp, bed_pkg::CODE_BEL);
          bed_pkg::CH_B:      grp = put(grp, bed_pkg::CODE_BS);
          bed_pkg::CH_F:      grp = put(grp, bed_pkg::CODE_FF);
          bed_pkg::CH_V:      grp = put(grp, bed_pkg::CODE_VT);
          bed_pkg::CH_E,
          bed_pkg::CH_E_UP:   grp = put(grp, bed_pkg::CODE_ESC);
          bed_pkg::CH_BSLASH: grp = put(grp, bed_pkg::CH_BSLASH);
          bed_pkg::CH_C: begin
            if (mode_has_c) phase_next = PH_STOP;
            else grp = put(grp, bed_pkg::CH_C);
          end
          bed_pkg::CH_X: begin
            if (item.in_last) begin
              if (mode_keeps_bslash) grp = put(grp, bed_pkg::CH_BSLASH);
              grp = put(grp, bed_pkg::CH_X);
            end else begin
              phase_next       = PH_HEX;
              digit_value_next = '0;
              digit_count_next = '0;
            end
          end
          default: begin
            if (is_oct) begin
              phase_next       = PH_OCT;
              digit_value_next = {6'd0, item.in_byte[2:0]};
              digit_count_next = 2'd1;
            end else begin
              // unknown escape
              if (mode_keeps_bslash) grp = put(grp, bed_pkg::CH_BSLASH);
              grp = put(grp, item.in_byte);
            end
          end
        endcase
      end
      PH_OCT: begin
        if (is_oct) begin
          digit_value_next = {digit_value[5:0], item.in_byte[2:0]};
          digit_count_next = digit_count + 2'd1;
          if (digit_count_next == 2'd3) begin
            grp        = put(grp, digit_value_next[7:0]);
            phase_next = PH_TEXT;
          end
        end else begin
          grp        = put(grp, digit_value[7:0]);
          phase_next = PH_TEXT;
          do_plain   = 1'b1;
        end
      end
      PH_HEX: begin
        if (hexd[4]) begin
          digit_value_next = {digit_value[4:0], hexd[3:0]};
          digit_count_next = digit_count + 2'd1;
          if (digit_count_next >= 2'd2) begin
            grp        = put(grp, digit_value_next[7:0]);
            phase_next = PH_TEXT;
          end
        end else begin
          if (digit_count == 2'd0) begin
            // bare \x
            if (mode_has_c) grp = put(grp, bed_pkg::CH_BSLASH);
            grp = put(grp, bed_pkg::CH_X);
          end else begin
            grp = put(grp, digit_value[7:0]);
          end
          phase_next = PH_TEXT;
          do_plain   = 1'b1;
        end
      end
      PH_STOP: begin
      end
      default: begin
        phase_next = PH_TEXT;
        do_plain   = 1'b1;
      end
    endcase

    // Byte handled as ordinary text
    if (do_plain) begin
      if (item.in_byte == bed_pkg::CH_BSLASH) begin
        if (item.in_last) grp = put(grp, bed_pkg::CH_BSLASH);
        else phase_next = PH_ESC;
      end else begin
        grp = put(grp, item.in_byte);
      end
    end

    // End of string: flush a pending run, mark the final result, clear state
    if (item.in_last) begin
      if ((phase_next == PH_OCT || phase_next == PH_HEX) && digit_count_next != 2'd0) begin
        grp = put(grp, digit_value_next[7:0]);
      end
      stopped = (phase_next == PH_STOP);
      if (grp.count == 2'd0) begin
        grp.items[0] = '{out_byte: 8'd0, byte_valid: 1'b0, run_last: 1'b0,
                         string_end: 1'b0, stopped_by_c: stopped};
        grp.count    = 2'd1;
      end
      grp.items[grp.count - 2'd1].string_end = 1'b1;
      phase_next       = PH_TEXT;
      digit_value_next = '0;
      digit_count_next = '0;
    end
    if (grp.count != 2'd0) begin
      grp.items[grp.count - 2'd1].run_last = 1'b1;
    end
  end

  // Decode state, updated once per transfer into the result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TEXT;
      digit_value <= '0;
      digit_count <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      digit_value <= digit_value_next;
      digit_count <= digit_count_next;
    end
  end

  `BED_ASSERT_NEXT(a_last_clears_state, clk, rst, advance && item.in_last,
    phase == PH_TEXT && digit_value == 9'd0 && digit_count == 2'd0)
  `BED_ASSERT_NOW(a_oct_count_range, clk, rst, phase == PH_OCT,
    digit_count == 2'd1 || digit_count == 2'd2)

endmodule

`default_nettype wire

@@ sv/bed_resq.sv @@
`default_nettype none

module bed_resq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire bed_pkg::group_t   grp,
  output logic                   ready,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bed_pkg::out_item_t     out_data
);

  `include "backslash_escape_decoder_core_assert.svh"

  logic [bed_pkg::CNT_W-1:0]                  cnt, cnt_next;
  bed_pkg::out_item_t [bed_pkg::MAX_RESULTS-1:0] items, items_next;
  logic                                        pop;

  assign out_valid = (cnt != '0);
  assign out_data  = items[0];
  assign pop       = out_valid && !out_stall;
  // a new group may enter once the stage is empty or drains this cycle
  assign ready     = (cnt == '0) || (cnt == 2'd1 && pop);

  // Load a whole group, or shift one result out per transfer
  always_comb begin
    cnt_next   = cnt;
    items_next = items;
    if (load) begin
      cnt_next   = grp.count;
      items_next = grp.items;
    end else if (pop) begin
      cnt_next      = cnt - 2'd1;
      items_next[0] = items[1];
      items_next[1] = items[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    items <= items_next;
  end

  `BED_ASSERT_NOW(a_load_only_when_free, clk, rst, load,
    cnt == 2'd0 || (cnt == 2'd1 && pop))
  `BED_ASSERT_NOW(a_end_is_run_last, clk, rst, out_valid && out_data.string_end,
    out_data.run_last)

endmodule

`default_nettype wire

@@ sv/backslash_escape_decoder_core.sv @@
`default_nettype none

// Backslash escape decoder. Raw string bytes go in, one per transfer, with
// in_last on the final byte of each string; decoded bytes come out, zero to
// three per input byte, the last of them flagged run_last and the last of the
// string flagged string_end (a string that leaves nothing gives one result
// with byte_valid low). A byte that yields several results holds the input
// until the last of them is leaving, since the result stage hands out one
// result per cycle while out_stall is low. A byte passes through the input
// register, then the result register. escape_mode may only be written
// while the block is idle.
module backslash_escape_decoder_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bed_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output bed_pkg::out_item_t      out_data
);

  logic [1:0]        mode;
  logic              hold_valid;
  bed_pkg::in_item_t hold;
  logic              accept;
  logic              advance;
  logic              ready;
  bed_pkg::group_t   grp;

  // Input register: frees as its byte moves into the result stage
  assign advance  = hold_valid && ready;
  assign in_stall = hold_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      mode       <= bed_pkg::MODE_RESET;
    end else begin
      hold_valid <= accept || (hold_valid && !advance);
      if (cfg_write) mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) hold <= in_data;
  end

  bed_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .item        (hold),
    .escape_mode (mode),
    .grp         (grp)
  );

  bed_resq u_resq (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .grp       (grp),
    .ready     (ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
